FILE: hw/rtl/utl_pkg.sv
// Shared types, constants and the lead byte classifier of the UTF-8 to Latin-1 stream core.
package utl_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned CAP_W             = 16;
  localparam int unsigned CP_W              = 21;
  localparam int unsigned OUTQ_DEPTH        = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;
  localparam logic [7:0]       QMARK     = 8'h3F;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_class_t;

  // One character ready for the result channel, position carried alongside.
  typedef struct packed {
    logic [7:0] ch;
    logic       stored;
    logic       last;
  } ent_t;

  typedef struct packed {
    logic vld;
    ent_t ent;
  } res_t;

  function automatic lead_class_t classify_lead(input logic [7:0] b);
    lead_class_t cls;
    case (b) inside
      8'b0???????: cls = LEAD_ASCII;
      8'b110?????: cls = LEAD_TWO;
      8'b1110????: cls = LEAD_THREE;
      8'b11110???: cls = LEAD_FOUR;
      default:     cls = LEAD_BAD;
    endcase
    return cls;
  endfunction

  function automatic logic is_trailing(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

endpackage

FILE: hw/rtl/utl_decode.sv
// Decoder state, capacity register and the per-byte result logic.
module utl_decode
  import utl_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_wdata,
  input  logic                     step,
  input  logic [7:0]               in_byte,
  input  logic                     in_end_of_text,
  output res_t                     res0,
  output res_t                     res1,
  output logic [POSITION_BITS-1:0] pos0,
  output logic [POSITION_BITS-1:0] pos1
);

  localparam int unsigned CMP_W = (POSITION_BITS > CAP_W) ? POSITION_BITS : CAP_W;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic [CAP_W-1:0]         cap_r;
  logic [1:0]               pend_r, pend_nxt;
  logic [CP_W-1:0]          cp_r, cp_nxt;
  logic                     skip_r, skip_nxt;
  logic [POSITION_BITS-1:0] wp_r, wp_nxt;

  logic            trailing;
  logic [CP_W-1:0] cp_sh;
  logic            a_v, b_v, c_v, do_lead;
  logic [7:0]      a_ch, b_ch;
  logic [POSITION_BITS-1:0] wp1, wp2;

  assign trailing = is_trailing(in_byte);
  assign cp_sh    = {cp_r[CP_W-7:0], in_byte[5:0]};

  always_comb begin
    pend_nxt = pend_r;
    cp_nxt   = cp_r;
    skip_nxt = skip_r;
    a_v      = 1'b0;
    a_ch     = QMARK;
    b_v      = 1'b0;
    b_ch     = in_byte;
    do_lead  = 1'b0;

    if (pend_r != 2'd0) begin
      if (trailing) begin
        pend_nxt = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          a_v    = 1'b1;
          a_ch   = (cp_sh[CP_W-1:8] == '0) ? cp_sh[7:0] : QMARK;
          cp_nxt = '0;
        end else begin
          cp_nxt = cp_sh;
        end
      end else begin
        // A new lead broke the sequence: flag it, then decode the byte afresh.
        a_v      = 1'b1;
        pend_nxt = 2'd0;
        cp_nxt   = '0;
        do_lead  = 1'b1;
      end
    end else if (!(skip_r && trailing)) begin
      skip_nxt = 1'b0;
      do_lead  = 1'b1;
    end

    if (do_lead) begin
      case (classify_lead(in_byte))
        LEAD_ASCII: b_v = 1'b1;
        LEAD_TWO: begin
          cp_nxt   = {{(CP_W-5){1'b0}}, in_byte[4:0]};
          pend_nxt = 2'd1;
        end
        LEAD_THREE: begin
          cp_nxt   = {{(CP_W-4){1'b0}}, in_byte[3:0]};
          pend_nxt = 2'd2;
        end
        LEAD_FOUR: begin
          cp_nxt   = {{(CP_W-3){1'b0}}, in_byte[2:0]};
          pend_nxt = 2'd3;
        end
        default: begin
          b_v      = 1'b1;
          b_ch     = QMARK;
          skip_nxt = 1'b1;
        end
      endcase
    end

    c_v = in_end_of_text && (pend_nxt != 2'd0);
    if (in_end_of_text) begin
      pend_nxt = 2'd0;
      cp_nxt   = '0;
      skip_nxt = 1'b0;
    end
  end

  // Compact the up to three emission slots into two results.
  assign wp1 = (wp_r == POS_MAX) ? wp_r : wp_r + 1'b1;
  assign wp2 = (wp1 == POS_MAX) ? wp1 : wp1 + 1'b1;
  assign pos0 = wp_r;
  assign pos1 = wp1;

  always_comb begin
    res0.vld        = a_v || b_v || c_v;
    res0.ent.ch     = a_v ? a_ch : (b_v ? b_ch : QMARK);
    res0.ent.stored = CMP_W'(wp_r) < CMP_W'(cap_r);
    res1.vld        = (a_v && (b_v || c_v)) || (b_v && c_v);
    res1.ent.ch     = (a_v && b_v) ? b_ch : QMARK;
    res1.ent.stored = CMP_W'(wp1) < CMP_W'(cap_r);
    res0.ent.last   = !res1.vld;
    res1.ent.last   = 1'b1;
  end

  always_comb begin
    if (in_end_of_text) begin
      wp_nxt = '0;
    end else if (res1.vld) begin
      wp_nxt = wp2;
    end else if (res0.vld) begin
      wp_nxt = wp1;
    end else begin
      wp_nxt = wp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      pend_r <= 2'd0;
      cp_r   <= '0;
      skip_r <= 1'b0;
      wp_r   <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (step) begin
        pend_r <= pend_nxt;
        cp_r   <= cp_nxt;
        skip_r <= skip_nxt;
        wp_r   <= wp_nxt;
      end
    end
  end

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    res1.vld |-> res0.vld)
    else $error("second result without a first");

  a_text_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_end_of_text |=> pend_r == 2'd0 && !skip_r && wp_r == '0 && cp_r == '0)
    else $error("decoder state not cleared after end of text");

  a_pending_has_payload: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 2'd0 |-> cp_r == '0)
    else $error("partial codepoint left without pending bytes");

endmodule

FILE: hw/rtl/utf8_to_latin1_stream_core.sv
// Top level of the UTF-8 to Latin-1 stream core: decoder and result queue.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_ready  in_byte, in_end_of_text
//   out_     output     out_valid/out_ready out_char, out_position, out_stored, out_run_last
//   cfg_     input      cfg_we             cfg_wdata (capacity)
//
// One byte is accepted per cycle while in_ready is high; its results sit in a four-entry queue from the next cycle.
// A byte that gives two results sends them out one after the other through the single read port.
// in_ready is high while the queue has room for two results, so a stalled output
// side fills the queue and then holds off input without dropping anything.
// Synchronous reset empties the queue, clears the decoder and sets capacity to 65535.
module utf8_to_latin1_stream_core
  import utl_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic                     in_end_of_text,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_char,
  output logic [POSITION_BITS-1:0] out_position,
  output logic                     out_stored,
  output logic                     out_run_last
);

  localparam int unsigned PTR_W = $clog2(OUTQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(OUTQ_DEPTH + 1);

  res_t                     res0, res1;
  logic [POSITION_BITS-1:0] pos0, pos1;
  logic                     push, pop;

  ent_t                     q_ent_r [OUTQ_DEPTH];
  logic [POSITION_BITS-1:0] q_pos_r [OUTQ_DEPTH];
  logic [PTR_W-1:0]         wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr1;
  logic [CNT_W-1:0]         count_r, count_nxt, n_push;

  assign in_ready = count_r <= CNT_W'(OUTQ_DEPTH - 2);
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  utl_decode #(
    .POSITION_BITS(POSITION_BITS)
  ) u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .step           (push),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .res0           (res0),
    .res1           (res1),
    .pos0           (pos0),
    .pos1           (pos1)
  );

  assign wr_ptr1 = wr_ptr_r + 1'b1;
  assign n_push  = push ? (CNT_W'(res0.vld) + CNT_W'(res1.vld)) : '0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + n_push - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push && res0.vld) begin
      q_ent_r[wr_ptr_r] <= res0.ent;
      q_pos_r[wr_ptr_r] <= pos0;
    end
    if (push && res1.vld) begin
      q_ent_r[wr_ptr1] <= res1.ent;
      q_pos_r[wr_ptr1] <= pos1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_valid    = count_r != '0;
  assign out_char     = q_ent_r[rd_ptr_r].ch;
  assign out_stored   = q_ent_r[rd_ptr_r].stored;
  assign out_run_last = q_ent_r[rd_ptr_r].last;
  assign out_position = q_pos_r[rd_ptr_r];

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(OUTQ_DEPTH))
    else $error("result queue overflow");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    PTR_W'(wr_ptr_r - rd_ptr_r) == PTR_W'(count_r))
    else $error("queue pointers disagree with fill count");

endmodule
